@@ rtl/core/vibrato_modulated_delay_assert.svh @@
// Assertion macros shared by the vibrato delay core.
`ifndef VIBRATO_MODULATED_DELAY_ASSERT_SVH
`define VIBRATO_MODULATED_DELAY_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent checked in the same cycle as the antecedent
`define VMD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent checked in the cycle after the antecedent
`define VMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VMD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define VMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/vmd_pkg.sv @@
package vmd_pkg;

   // Field and register widths
   localparam int SAMPLE_W       = 16;
   localparam int DEPTH_Q8_W     = 17;
   localparam int PHASE_STEP_W   = 31;
   localparam int PHASE_W        = 32;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 31;

   // Register reset values
   localparam logic [DEPTH_Q8_W-1:0]   DEPTH_Q8_RST   = 17'd4608;
   localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = 31'd178957;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_Q8   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = 2'd1;

   // Delay store default length
   localparam int DELAY_DEPTH_DEF = 1024;

   // Delay value: integer samples and 8 fraction bits
   localparam int DINT_W = 10;
   localparam int FRAC_W = 8;

   // Quarter-wave sine table
   localparam int SINE_TABLE_SIZE = 256;
   localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE + 1);
   localparam int SINE_ENTRY_W    = 15;
   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam longint unsigned SINE_DIV = 2 * SINE_TABLE_SIZE;

   // Shared multiplier operand select
   typedef enum logic [1:0] {
      MUL_DELAY  = 2'd0,
      MUL_TAP_A  = 2'd1,
      MUL_TAP_B  = 2'd2
   } mul_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        accept;
      logic        sine_load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        split_load;
      logic        reduce;
      logic        mem_read;
      logic        acc_load;
      logic        finish;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic reduced;
   } dp_status_type;

   // sin(pi/2 * k / SINE_TABLE_SIZE) in Q1.15, Taylor series in Q30, rounded
   function automatic logic [SINE_ENTRY_W-1:0] sine_quarter_entry(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      x    = (longint'(k) * PI_Q30) / SINE_DIV;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end
      return SINE_ENTRY_W'(r);
   endfunction

endpackage

@@ rtl/core/vmd_ctrl.sv @@
`include "vibrato_modulated_delay_assert.svh"

module vmd_ctrl
   import vmd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SINE   = 9'b000000010,
      ST_DELAY  = 9'b000000100,
      ST_SPLIT  = 9'b000001000,
      ST_REDUCE = 9'b000010000,
      ST_READ_A = 9'b000100000,
      ST_MUL_A  = 9'b001000000,
      ST_MUL_B  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a result this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencer: next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_DELAY;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SINE;
            end
         end
         ST_SINE: begin
            cmd.sine_load = 1'b1;
            state_in      = ST_DELAY;
         end
         ST_DELAY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DELAY;
            state_in    = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split_load = 1'b1;
            state_in       = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (status.reduced) begin
               state_in = ST_READ_A;
            end
         end
         ST_READ_A: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mem_read = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_TAP_A;
            state_in     = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_TAP_B;
            cmd.acc_load = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `VMD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "input accepted twice in a row")
   `VMD_ASSERT_NEXT(a_finish_shows_result, clock, reset, cmd.finish, rsp_valid, "finished item not presented")
   `VMD_ASSERT_SAME(a_result_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result appeared outside completion")

endmodule

@@ rtl/core/vmd_dpath.sv @@
`include "vibrato_modulated_delay_assert.svh"

module vmd_dpath
   import vmd_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status
);

   localparam int AW    = $clog2(DELAY_DEPTH);
   localparam int CW    = ((DINT_W > AW) ? DINT_W : AW) + 1;
   localparam int SCL_W = 30 + SINE_IDX_W;
   localparam logic [AW:0]   DEPTH_W   = (AW+1)'(DELAY_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DELAY_DEPTH);

   // configuration and running state
   logic [DEPTH_Q8_W-1:0]   depth_ff, depth_in;
   logic [PHASE_STEP_W-1:0] step_ff, step_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic                    wrapped_ff, wrapped_in;

   // per-item working registers
   logic [SINE_IDX_W-1:0]      sine_idx_ff;
   logic                       sine_neg_ff;
   logic signed [SAMPLE_W-1:0] sine_ff;
   logic signed [33:0]         prod_ff;
   logic [DINT_W-1:0]          rem_ff;
   logic [FRAC_W-1:0]          frac_ff;
   logic [FRAC_W-1:0]          f_ff;
   logic [AW-1:0]              addr_ff;
   logic [SAMPLE_W-1:0]        rd_ff;
   logic                       rd_vld_ff;
   logic signed [24:0]         acc_ff;
   logic signed [SAMPLE_W-1:0] out_ff;

   logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
   logic [SINE_ENTRY_W-1:0] sine_rom [SINE_TABLE_SIZE+1];

   // constant quarter-wave table
   for (genvar k = 0; k <= SINE_TABLE_SIZE; k++) begin : g_rom
      assign sine_rom[k] = sine_quarter_entry(k);
   end

   // config register writes and end-of-item advance
   always_comb begin
      depth_in   = depth_ff;
      step_in    = step_ff;
      phase_in   = phase_ff;
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DEPTH_Q8:   depth_in = csr_write_data[DEPTH_Q8_W-1:0];
            CSR_PHASE_STEP: step_in  = csr_write_data[PHASE_STEP_W-1:0];
            default: begin
            end
         endcase
      end
      if (cmd.finish) begin
         phase_in = phase_ff + PHASE_W'(step_ff);
         if (wp_ff == LAST_ADDR) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= DEPTH_Q8_RST;
         step_ff    <= PHASE_STEP_RST;
         phase_ff   <= '0;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         step_ff    <= step_in;
         phase_ff   <= phase_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // table position from the current phase
   logic [SCL_W-1:0]      scaled;
   logic [SINE_IDX_W-1:0] pos;
   logic [SINE_IDX_W-1:0] sine_idx_in;
   logic [SINE_ENTRY_W-1:0] sine_mag;

   always_comb begin
      scaled = SCL_W'(phase_ff[29:0]) * SCL_W'(SINE_TABLE_SIZE);
      pos    = scaled[SCL_W-1:30];
      if (pos > SINE_IDX_W'(SINE_TABLE_SIZE)) begin
         pos = SINE_IDX_W'(SINE_TABLE_SIZE);
      end
      sine_idx_in = phase_ff[30] ? (SINE_IDX_W'(SINE_TABLE_SIZE) - pos) : pos;
      sine_mag    = sine_rom[sine_idx_ff];
   end

   // shared multiplier, operands picked per step
   logic signed [17:0]         mul_a, mul_b;
   logic signed [35:0]         mul_p;
   logic signed [SAMPLE_W-1:0] tap;

   always_comb begin
      tap = rd_vld_ff ? signed'(rd_ff) : '0;
      case (cmd.mul_sel)
         MUL_DELAY: begin
            mul_a = signed'({1'b0, depth_ff});
            mul_b = signed'({2'b00, ~sine_ff[SAMPLE_W-1], sine_ff[SAMPLE_W-2:0]});
         end
         MUL_TAP_A: begin
            mul_a = {{2{tap[SAMPLE_W-1]}}, tap};
            mul_b = signed'({9'd0, 9'd256 - {1'b0, f_ff}});
         end
         MUL_TAP_B: begin
            mul_a = {{2{tap[SAMPLE_W-1]}}, tap};
            mul_b = signed'({10'd0, f_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // delay reduction modulo the store length and read address
   logic [CW-1:0] rem_ext;
   logic [AW-1:0] d_int;
   logic [AW:0]   back;
   logic [AW-1:0] i1;

   always_comb begin
      rem_ext        = CW'(rem_ff);
      status.reduced = (rem_ext < DEPTH_C);
      d_int          = AW'(rem_ext);
      back           = {1'b0, wp_ff} - {1'b0, d_int} - (AW+1)'(frac_ff != '0);
      if (back[AW]) begin
         back = back + DEPTH_W;
      end
      i1 = back[AW-1:0];
   end

   // interpolation sum, floor of division by 256
   logic signed [25:0] sum;
   assign sum = {acc_ff[24], acc_ff} + {prod_ff[24], prod_ff[24:0]};

   // per-item datapath registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sine_idx_ff <= sine_idx_in;
         sine_neg_ff <= phase_ff[31];
      end
      if (cmd.sine_load) begin
         sine_ff <= sine_neg_ff ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});
      end
      if (cmd.mul_en) begin
         prod_ff <= 34'(mul_p);
      end
      if (cmd.split_load) begin
         rem_ff  <= prod_ff[32:23];
         frac_ff <= prod_ff[22:15];
      end
      if (cmd.reduce) begin
         if (status.reduced) begin
            addr_ff <= i1;
            f_ff    <= 8'd0 - frac_ff;
         end else begin
            rem_ff <= DINT_W'(rem_ext - DEPTH_C);
         end
      end
      if (cmd.mem_read) begin
         addr_ff   <= (addr_ff == LAST_ADDR) ? '0 : addr_ff + AW'(1);
         rd_vld_ff <= wrapped_ff || (addr_ff <= wp_ff);
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff[24:0];
      end
      if (cmd.finish) begin
         out_ff <= sum[23:8];
      end
   end

   // delay store: write on accept, registered read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wp_ff] <= req_sample_in;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[addr_ff];
      end
   end

   assign rsp_sample_out = out_ff;

   `VMD_ASSERT_SAME(a_wp_in_range, clock, reset, 1'b1, {1'b0, wp_ff} < DEPTH_W, "write pointer beyond store")
   `VMD_ASSERT_SAME(a_read_in_range, clock, reset, cmd.mem_read, {1'b0, addr_ff} < DEPTH_W, "read address beyond store")
   `VMD_ASSERT_NEXT(a_reduce_shrinks, clock, reset, cmd.reduce && !status.reduced, rem_ff < $past(rem_ff), "delay reduction did not shrink")

endmodule

@@ rtl/core/vibrato_modulated_delay.sv @@
// Channel   Ports                                Beat
// input     req_valid/req_ready, req_sample_in   one Q1.15 sample
// result    rsp_valid/rsp_ready, rsp_sample_out  one interpolated sample
// config    csr_write_en, csr_index, csr_write_data  register write, no wait
//
// Steps per sample: accept, sine, delay product, split, delay modulo,
//   read, tap A, tap B, done; the delay modulo step takes k extra passes,
//   k = floor(delay / DELAY_DEPTH) (k is 0 for DELAY_DEPTH >= 1024).
// One shared 18x18 multiplier and the single delay store port set this step order.
// Reset: synchronous; clears pointer, phase and wrap flag, loads register reset values.
//   Unwritten store entries read as zero through the wrap flag; no clearing pass.
// A held result stalls only the final step; no new sample is taken until that step ends.
module vibrato_modulated_delay
   import vmd_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                        csr_write_en,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   vmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   vmd_dpath #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

@@ bench/tb_vibrato_modulated_delay.sv @@
module tb_vibrato_modulated_delay;
   import vmd_pkg::*;

   localparam int  LINE_LEN   = DELAY_DEPTH_DEF;
   localparam int  QSINE_N    = SINE_TABLE_SIZE;
   localparam longint SPAN_Q8 = longint'(LINE_LEN) * 256;
   // pi in Q30, drives the quarter-wave table build
   localparam longint unsigned PI_Q30_TB = 64'd3373259426;
   localparam int  SETTLE_CYC = 24;
   localparam int  STALL_LIMIT = 2000;
   localparam int  RAND_PHASES = 9;
   localparam int  PHASE_BEATS = 150;

   // Spare register slots, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // Predicts the vibrato output and holds the samples still owed
   class vibrato_scoreboard;
      shortint                     line_mem[LINE_LEN];
      int                          qsine[QSINE_N + 1];
      int                          wr_ptr;
      bit [PHASE_W-1:0]            lfo;
      bit [DEPTH_Q8_W-1:0]         depth;
      bit [PHASE_STEP_W-1:0]       step;
      logic signed [SAMPLE_W-1:0]  owed_q[$];
      int                          errors;
      int                          checked;

      function new();
         for (int k = 0; k <= QSINE_N; k++) begin
            qsine[k] = sine_entry(k);
         end
         foreach (line_mem[i]) begin
            line_mem[i] = 0;
         end
         wr_ptr  = 0;
         lfo     = '0;
         depth   = DEPTH_Q8_RST;
         step    = PHASE_STEP_RST;
         errors  = 0;
         checked = 0;
      endfunction

      // Q30 Taylor series of sin(pi/2 * k/N), rounded to Q1.15
      function int sine_entry(int k);
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint          sum;
         longint          r;
         x    = (longint'(k) * PI_Q30_TB) / (2 * QSINE_N);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (sum + 16384) >>> 15;
         if (r > 32767) begin
            r = 32767;
         end
         return int'(r);
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DEPTH_Q8: begin
               depth = data[DEPTH_Q8_W-1:0];
            end
            CSR_PHASE_STEP: begin
               step = data[PHASE_STEP_W-1:0];
            end
            default: begin
               // spare slots hold nothing
            end
         endcase
      endfunction

      // Accepted input beat: write the line, interpolate the tap
      function void note_sample(logic signed [SAMPLE_W-1:0] x);
         int     s;
         int     idx;
         int     i1;
         int     i2;
         int     fr;
         longint dly;
         longint rd;
         longint acc;
         line_mem[wr_ptr] = x;
         idx = lfo[29:22];
         if (lfo[30]) begin
            idx = QSINE_N - idx;
         end
         s = qsine[idx];
         if (lfo[31]) begin
            s = -s;
         end
         dly = (longint'(depth) * longint'(32768 + s)) >>> 15;
         rd  = (longint'(wr_ptr) * 256 - dly) % SPAN_Q8;
         if (rd < 0) begin
            rd = rd + SPAN_Q8;
         end
         i1  = int'(rd >>> 8);
         fr  = int'(rd & 255);
         i2  = (i1 + 1) % LINE_LEN;
         acc = longint'(line_mem[i1]) * (256 - fr) + longint'(line_mem[i2]) * fr;
         owed_q.push_back(SAMPLE_W'(acc >>> 8));
         wr_ptr = (wr_ptr + 1) % LINE_LEN;
         lfo    = lfo + step;
      endfunction

      function void check_out(logic signed [SAMPLE_W-1:0] y);
         logic signed [SAMPLE_W-1:0] exp_y;
         if (owed_q.size() == 0) begin
            $error("sample_out with no sample pending: expected none, actual %0d", y);
            errors++;
         end else begin
            exp_y = owed_q.pop_front();
            checked++;
            if (y !== exp_y) begin
               $error("sample_out mismatch: expected %0d, actual %0d", exp_y, y);
               errors++;
            end
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_sample_in;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [SAMPLE_W-1:0]  rsp_sample_out;
   logic                        csr_write_en;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_write_data;

   vibrato_scoreboard sb = new();
   bit calm = 1'b0;
   int settings_seen = 0;

   vibrato_modulated_delay #(
      .DELAY_DEPTH(LINE_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Beat monitor: inputs feed the predictor, results are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_sample(req_sample_in);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_out(rsp_sample_out);
         end
      end
   end

   // Result side backpressure, short random bursts
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   // Watchdog on cycles without any beat
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("tb_vibrato_modulated_delay NOT OK");
      $finish;
   end

   // Send one sample and wait for its beat; called at a falling edge
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
      req_sample_in = s;
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
      if (!calm && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index      = idx;
      csr_write_data = data;
      csr_write_en   = 1'b1;
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Wait until every owed sample is back, then let the pipe go quiet
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_depth();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CSR_DATA_W'(17'h1FFFF);
         2:       return CSR_DATA_W'($urandom_range(0, 4095));
         3:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(0, 130815));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_step();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return {CSR_DATA_W{1'b1}};
         2:       return CSR_DATA_W'($urandom_range(0, 1 << 22));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample_in  = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_DEPTH_Q8;
      csr_write_data = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      settings_seen++;

      // Reset settings: extremes and alternating bit patterns
      push_sample(16'sh7FFF);
      push_sample(-16'sh8000);
      push_sample(16'sh0000);
      push_sample(-16'sh0001);
      push_sample(16'sh5555);
      push_sample(SAMPLE_W'(16'hAAAA));
      drain();

      // Zero delay reads back the fresh sample; spare slots are ignored
      write_reg(CSR_SPARE_A, {CSR_DATA_W{1'b1}});
      write_reg(CSR_SPARE_B, CSR_DATA_W'($urandom));
      write_reg(CSR_DEPTH_Q8, '0);
      settings_seen++;
      push_sample(16'sh7FFF);
      push_sample(-16'sh8000);
      push_sample(16'sh0001);
      push_sample(-16'sh0002);
      drain();

      // Over-wide depth keeps its low bits; largest step wraps the phase
      write_reg(CSR_DEPTH_Q8, {CSR_DATA_W{1'b1}});
      write_reg(CSR_PHASE_STEP, {CSR_DATA_W{1'b1}});
      settings_seen++;
      for (int i = 0; i < 8; i++) begin
         push_sample((i % 2 == 0) ? 16'sh7FFF : -16'sh8000);
      end
      drain();

      // One-sample depth setting, frozen oscillator
      write_reg(CSR_DEPTH_Q8, CSR_DATA_W'(256));
      write_reg(CSR_PHASE_STEP, '0);
      settings_seen++;
      for (int i = 0; i < 5; i++) begin
         push_sample(SAMPLE_W'(i * 7000 - 14000));
      end
      drain();

      // Random phases, each under a fresh register setting
      for (int p = 0; p < RAND_PHASES; p++) begin
         calm = (p >= RAND_PHASES - 2);
         write_reg(CSR_DEPTH_Q8, pick_depth());
         write_reg(CSR_PHASE_STEP, pick_step());
         if ($urandom_range(0, 2) == 0) begin
            write_reg(($urandom_range(0, 1) == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                      CSR_DATA_W'($urandom));
         end
         settings_seen++;
         for (int i = 0; i < PHASE_BEATS; i++) begin
            push_sample(pick_sample());
         end
         drain();
      end

      $display("run covered %0d register settings, %0d output beats checked",
               settings_seen, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_vibrato_modulated_delay OK");
      end else begin
         $display("%0d errors, %0d samples never returned", sb.errors, sb.pending());
         $display("tb_vibrato_modulated_delay NOT OK");
      end
      $finish;
   end

endmodule
